// File: design/gbte_pkg.sv
// Package for the gap buffer text editor.
// Holds sizes, operation and status codes, and the structs shared by the modules.
// No dependencies.
package gbte_pkg;

	localparam int CAPACITY = 4096;
	localparam int AW       = $clog2(CAPACITY);
	localparam int PW       = 13;
	localparam int DW       = 8;

	typedef logic [AW-1:0] addr_t;
	typedef logic [PW-1:0] pos_t;
	typedef logic [DW-1:0] char_t;

	typedef enum logic [2:0] {
		KIND_SET       = 3'd0,
		KIND_MOVE      = 3'd1,
		KIND_INSERT    = 3'd2,
		KIND_BKSP      = 3'd3,
		KIND_FDEL      = 3'd4,
		KIND_RD_AT     = 3'd5,
		KIND_RD_CUR    = 3'd6,
		KIND_RD_BEFORE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NONE  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		char_t wr_data;
	} mem_req_t;

	typedef struct packed {
		status_t status;
		char_t   char_out;
		pos_t    cursor_pos;
		pos_t    text_length;
	} result_t;

endpackage

// File: design/gbte_mem.sv
// Text store: single-port-write, single-port-read synchronous RAM.
// Registered read data: it appears in the cycle after the read request. Uses gbte_pkg.
module gbte_mem (
	input  logic                clk,
	input  gbte_pkg::mem_req_t  req,
	output gbte_pkg::char_t     rd_data
);

	gbte_pkg::char_t mem_q [gbte_pkg::CAPACITY];
	gbte_pkg::char_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/gbte_ctrl.sv
// Gap buffer sequencer: gap pointers, cursor, operation decode and gap moves.
// Drives the text store through a request struct. Uses gbte_pkg.
module gbte_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gbte_pkg::kind_t     kind,
	input  gbte_pkg::pos_t      position,
	input  logic [13:0]         delta,
	input  gbte_pkg::char_t     new_char,
	output gbte_pkg::mem_req_t  mem_req,
	input  gbte_pkg::char_t     mem_rd_data,
	output logic                res_valid,
	input  logic                res_ready,
	output gbte_pkg::result_t   res
);

	localparam gbte_pkg::pos_t CAP = gbte_pkg::PW'(gbte_pkg::CAPACITY);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_GAP    = 7'b0000100,
		S_GAP_WR = 7'b0001000,
		S_ACT    = 7'b0010000,
		S_FETCH  = 7'b0100000,
		S_RESULT = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	gbte_pkg::kind_t   kind_q, kind_d;
	gbte_pkg::pos_t    pos_q, pos_d;
	logic [13:0]       delta_q, delta_d;
	gbte_pkg::char_t   nchar_q, nchar_d;
	gbte_pkg::pos_t    gb_q, gb_d, gf_q, gf_d, ca_q, ca_d;
	gbte_pkg::status_t status_q, status_d;
	gbte_pkg::char_t   ch_q, ch_d;
	logic              dir_q, dir_d;	// 1: gap moves down (copy top-down)

	gbte_pkg::pos_t gl, len, cur, rd_pos, rd_phys;
	logic [14:0]    np;

	assign gl  = gf_q - gb_q;
	assign len = CAP - gl;
	assign cur = (ca_q <= gb_q) ? ca_q : ca_q - gl;
	assign np  = {2'b00, cur} + {delta_q[13], delta_q};

	// position targeted by the three read kinds
	always_comb begin
		rd_pos = cur;
		case (kind_q)
			gbte_pkg::KIND_RD_AT:     rd_pos = pos_q;
			gbte_pkg::KIND_RD_BEFORE: rd_pos = (cur == '0) ? '0 : cur - 1'b1;
			default:                  rd_pos = cur;
		endcase
	end
	assign rd_phys = (rd_pos >= gb_q) ? rd_pos + gl : rd_pos;

	function automatic gbte_pkg::pos_t place(gbte_pkg::pos_t p);
		return (p > gb_q) ? p + gl : p;
	endfunction

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		pos_d    = pos_q;
		delta_d  = delta_q;
		nchar_d  = nchar_q;
		gb_d     = gb_q;
		gf_d     = gf_q;
		ca_d     = ca_q;
		status_d = status_q;
		ch_d     = ch_q;
		dir_d    = dir_q;
		mem_req  = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					kind_d  = kind;
					pos_d   = position;
					delta_d = delta;
					nchar_d = new_char;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = gbte_pkg::ST_OK;
				ch_d     = '0;
				state_d  = S_RESULT;
				unique case (kind_q) inside
					gbte_pkg::KIND_SET: begin
						if (pos_q > len) status_d = gbte_pkg::ST_RANGE;
						else ca_d = place(pos_q);
					end
					gbte_pkg::KIND_MOVE: begin
						if (np[14] || (np[13:0] > {1'b0, len})) status_d = gbte_pkg::ST_RANGE;
						else ca_d = place(np[gbte_pkg::PW-1:0]);
					end
					gbte_pkg::KIND_INSERT: begin
						if (gb_q >= gf_q) status_d = gbte_pkg::ST_FULL;
						else state_d = S_GAP;
					end
					gbte_pkg::KIND_BKSP: begin
						if (cur == '0) status_d = gbte_pkg::ST_NONE;
						else state_d = S_GAP;
					end
					gbte_pkg::KIND_FDEL: begin
						state_d = S_GAP;
					end
					gbte_pkg::KIND_RD_AT, gbte_pkg::KIND_RD_CUR,
					gbte_pkg::KIND_RD_BEFORE: begin
						if (rd_pos == len) begin
							status_d = gbte_pkg::ST_NONE;
						end else if (rd_pos > len) begin
							status_d = gbte_pkg::ST_RANGE;
						end else begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = rd_phys[gbte_pkg::AW-1:0];
							state_d         = S_FETCH;
						end
					end
					default: state_d = S_RESULT;
				endcase
			end
			S_GAP: begin
				if (ca_q == gb_q) begin
					state_d = S_ACT;
				end else if (ca_q < gb_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = gbte_pkg::AW'(gb_q - 1'b1);
					dir_d           = 1'b1;
					state_d         = S_GAP_WR;
				end else if (ca_q > gf_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = gf_q[gbte_pkg::AW-1:0];
					dir_d           = 1'b0;
					state_d         = S_GAP_WR;
				end else begin
					// cursor at the gap's upper edge (or inside it): gap is there already
					ca_d    = gb_q;
					state_d = S_ACT;
				end
			end
			S_GAP_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_data = mem_rd_data;
				if (dir_q) begin
					mem_req.wr_addr = gbte_pkg::AW'(gf_q - 1'b1);
					gb_d            = gb_q - 1'b1;
					gf_d            = gf_q - 1'b1;
				end else begin
					mem_req.wr_addr = gb_q[gbte_pkg::AW-1:0];
					gb_d            = gb_q + 1'b1;
					gf_d            = gf_q + 1'b1;
				end
				state_d = S_GAP;
			end
			S_ACT: begin
				state_d = S_RESULT;
				unique case (kind_q) inside
					gbte_pkg::KIND_INSERT: begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = gb_q[gbte_pkg::AW-1:0];
						mem_req.wr_data = nchar_q;
						gb_d            = gb_q + 1'b1;
						ca_d            = gb_q + 1'b1;
					end
					gbte_pkg::KIND_BKSP: begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = gbte_pkg::AW'(gb_q - 1'b1);
						gb_d            = gb_q - 1'b1;
						ca_d            = gb_q - 1'b1;
						state_d         = S_FETCH;
					end
					gbte_pkg::KIND_FDEL: begin
						if (gf_q >= CAP) begin
							status_d = gbte_pkg::ST_NONE;
						end else begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = gf_q[gbte_pkg::AW-1:0];
							gf_d            = gf_q + 1'b1;
							state_d         = S_FETCH;
						end
					end
					default: state_d = S_RESULT;
				endcase
			end
			S_FETCH: begin
				ch_d    = mem_rd_data;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign res.status      = status_q;
	assign res.char_out    = (status_q == gbte_pkg::ST_OK) ? ch_q : '0;
	assign res.cursor_pos  = cur;
	assign res.text_length = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gb_q    <= '0;
			gf_q    <= CAP;
			ca_q    <= '0;
		end else begin
			state_q <= state_d;
			gb_q    <= gb_d;
			gf_q    <= gf_d;
			ca_q    <= ca_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		pos_q    <= pos_d;
		delta_q  <= delta_d;
		nchar_q  <= nchar_d;
		status_q <= status_d;
		ch_q     <= ch_d;
		dir_q    <= dir_d;
	end

endmodule

// File: design/gap_buffer_text_editor.sv
// Gap buffer text editor, top level: stream ports, sequencer, text store, output register.
// Set and move go straight to the result, reads fetch one byte from the store, and insert and
// deletes first walk the gap to the cursor byte by byte; that gap-move copy loop dominates.
// A new input item is taken only after the previous result has moved to the output register.
// Reset (arst_n low, async): empty text, gap over the whole store, cursor 0, no result held.
// Depends on gbte_pkg, gbte_ctrl, gbte_mem.
module gap_buffer_text_editor (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,	// position[12:0], delta[26:13], new_char[34:27], zero pad
	input  logic [2:0]  s_axis_tuser,	// kind[2:0]
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,	// char_out[7:0], cursor_pos[20:8], text_length[33:21], pad
	output logic [1:0]  m_axis_tuser	// status[1:0]
);

	gbte_pkg::mem_req_t mem_req;
	gbte_pkg::char_t    mem_rd_data;
	gbte_pkg::result_t  res;
	logic               res_valid;
	logic               res_ready;

	logic               m_valid_q;
	logic [39:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	// Sequencer: decodes the op, walks the gap to the cursor byte by byte, applies the edit.
	gbte_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.kind        (gbte_pkg::kind_t'(s_axis_tuser)),
		.position    (s_axis_tdata[12:0]),
		.delta       (s_axis_tdata[26:13]),
		.new_char    (s_axis_tdata[34:27]),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Text store, registered read data.
	gbte_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	// Output register: sequencer can take the next transfer while a result waits here.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {6'b0, res.text_length, res.cursor_pos, res.char_out};
			m_tuser_q <= res.status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

// File: design/gbte_checker.sv
// Port-level checks for gap_buffer_text_editor, attached with bind.
// Uses gbte_pkg.
module gbte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	localparam logic [12:0] CAP = 13'(gbte_pkg::CAPACITY);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[33:21] <= CAP) &&
			(m_axis_tdata[20:8] <= m_axis_tdata[33:21]))
		else $error("cursor or length out of range");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != gbte_pkg::ST_OK) |-> m_axis_tdata[7:0] == 8'd0)
		else $error("char_out nonzero on failed op");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == gbte_pkg::ST_FULL) |-> m_axis_tdata[33:21] == CAP)
		else $error("full reported below capacity");

endmodule

bind gap_buffer_text_editor gbte_checker u_gbte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb_top.sv
// Testbench for gap_buffer_text_editor: directed corners, random edits and a fill to capacity.
// Results are checked against an in-bench model of the logical text and cursor.
// Depends on gbte_pkg and the gap_buffer_text_editor RTL.
`timescale 1ns / 100ps

module tb_top;
	import gbte_pkg::*;

	// clock and reset
	logic clk;
	logic arst_n = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// stream ports
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;	// position[12:0], delta[26:13], new_char[34:27], zero pad
	logic [2:0]  s_axis_tuser  = '0;	// kind[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;	// char_out[7:0], cursor_pos[20:8], text_length[33:21], pad
	logic [1:0]  m_axis_tuser;	// status[1:0]

	gap_buffer_text_editor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Model of the editor kept in logical order: text bytes [0, txt_len), cursor in [0, txt_len].
	// The physical gap position cannot be observed, so it is not modeled.
	char_t   txt_bytes [0:CAPACITY-1];
	int      txt_len;
	int      txt_cursor;

	result_t expected_results[$];	// one per accepted edit, oldest first

	int  mismatches;
	int  edits_sent;
	int  results_seen;
	int  status_seen [4];
	int  max_len_seen;
	bit  src_bursts;	// sender inserts idle bursts
	bit  sink_bursts;	// receiver stalls in bursts

	task automatic report_mismatch(string msg);
		if (mismatches < 20)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// Apply one edit to the model and return the result the block must give.
	function automatic result_t predict_edit(kind_t k, pos_t p, logic signed [13:0] d, char_t c);
		result_t r;
		status_t st;
		char_t   ch;
		int      target;

		st = ST_OK;
		ch = '0;
		case (k)
		KIND_SET: begin
			if (int'(p) > txt_len)
				st = ST_RANGE;
			else
				txt_cursor = int'(p);
		end
		KIND_MOVE: begin
			target = txt_cursor + int'(d);
			if (target < 0 || target > txt_len)
				st = ST_RANGE;
			else
				txt_cursor = target;
		end
		KIND_INSERT: begin
			// refused when full; nothing moves
			if (txt_len == CAPACITY) begin
				st = ST_FULL;
			end else begin
				for (int i = txt_len; i > txt_cursor; i--)
					txt_bytes[i] = txt_bytes[i-1];
				txt_bytes[txt_cursor] = c;
				txt_len++;
				txt_cursor++;
			end
		end
		KIND_BKSP: begin
			if (txt_cursor == 0) begin
				st = ST_NONE;
			end else begin
				ch = txt_bytes[txt_cursor-1];
				for (int i = txt_cursor - 1; i < txt_len - 1; i++)
					txt_bytes[i] = txt_bytes[i+1];
				txt_len--;
				txt_cursor--;
			end
		end
		KIND_FDEL: begin
			if (txt_cursor == txt_len) begin
				st = ST_NONE;
			end else begin
				ch = txt_bytes[txt_cursor];
				for (int i = txt_cursor; i < txt_len - 1; i++)
					txt_bytes[i] = txt_bytes[i+1];
				txt_len--;
			end
		end
		default: begin
			// reads: at a position, at the cursor, or before it (cursor 0 reads position 0)
			if (k == KIND_RD_AT)
				target = int'(p);
			else if (k == KIND_RD_CUR)
				target = txt_cursor;
			else
				target = (txt_cursor == 0) ? 0 : txt_cursor - 1;
			if (target == txt_len)
				st = ST_NONE;
			else if (target > txt_len)
				st = ST_RANGE;
			else
				ch = txt_bytes[target];
		end
		endcase

		r.status      = st;
		r.char_out    = (st == ST_OK) ? ch : '0;
		r.cursor_pos  = pos_t'(txt_cursor);
		r.text_length = pos_t'(txt_len);
		if (txt_len > max_len_seen)
			max_len_seen = txt_len;
		return r;
	endfunction

	// Send one edit. Called at a rising edge; returns at the edge of the transfer with
	// tvalid still high, so back-to-back edits keep it high without a glitch.
	task automatic send_edit(kind_t k, pos_t p, logic signed [13:0] d, char_t c);
		int idle;

		if (src_bursts && $urandom_range(0, 3) == 0) begin
			idle = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, c, d, p};
		s_axis_tuser  <= k;
		expected_results.push_back(predict_edit(k, p, d, c));
		edits_sent++;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Receiver: ready, with random stall bursts of random length when enabled.
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (sink_bursts && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result checker: every transfer on the result side is matched to the oldest expectation.
	always @(posedge clk) begin
		result_t want;

		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: status %0d char %02h",
					m_axis_tuser, m_axis_tdata[7:0]));
			end else begin
				want = expected_results.pop_front();
				status_seen[want.status]++;
				if (m_axis_tuser !== want.status)
					report_mismatch($sformatf("result %0d status %0d, want %0d",
						results_seen, m_axis_tuser, want.status));
				if (m_axis_tdata[7:0] !== want.char_out)
					report_mismatch($sformatf("result %0d char %02h, want %02h",
						results_seen, m_axis_tdata[7:0], want.char_out));
				if (m_axis_tdata[20:8] !== want.cursor_pos)
					report_mismatch($sformatf("result %0d cursor %0d, want %0d",
						results_seen, m_axis_tdata[20:8], want.cursor_pos));
				if (m_axis_tdata[33:21] !== want.text_length)
					report_mismatch($sformatf("result %0d length %0d, want %0d",
						results_seen, m_axis_tdata[33:21], want.text_length));
			end
		end
	end

	// Empty-text boundaries, out-of-range requests, field extremes and gap moves on a short text.
	task automatic test_corners();
		send_edit(KIND_RD_CUR,    '0, '0, '0);		// empty: read at cursor -> none
		send_edit(KIND_RD_BEFORE, '0, '0, '0);		// empty: read before cursor 0 -> none
		send_edit(KIND_BKSP,      '0, '0, '0);		// backspace at start
		send_edit(KIND_FDEL,      '0, '0, '0);		// forward delete at end
		send_edit(KIND_RD_AT,     '0, '0, '0);		// read at end
		send_edit(KIND_RD_AT,     13'h1fff, '0, '0);	// read far past end
		send_edit(KIND_SET,       13'd1, '0, '0);	// set past end
		send_edit(KIND_MOVE,      '0, 14'sd1, '0);
		send_edit(KIND_MOVE,      '0, -14'sd1, '0);
		send_edit(KIND_INSERT,    '0, '0, 8'h00);
		send_edit(KIND_INSERT,    '0, '0, 8'hff);
		send_edit(KIND_INSERT,    '0, '0, 8'h5a);
		send_edit(KIND_SET,       13'd0, '0, '0);
		send_edit(KIND_RD_BEFORE, '0, '0, '0);		// cursor 0 reads the first byte
		send_edit(KIND_MOVE,      '0, 14'sd3, '0);	// to the end
		send_edit(KIND_RD_CUR,    '0, '0, '0);		// cursor at end -> none
		send_edit(KIND_MOVE,      '0, 14'h2000, '0);	// most negative delta
		send_edit(KIND_MOVE,      '0, 14'h1fff, '0);	// most positive delta
		send_edit(KIND_SET,       13'd1, '0, '0);
		send_edit(KIND_INSERT,    '0, '0, 8'ha5);	// gap moves back to position 1
		send_edit(KIND_FDEL,      '0, '0, '0);
		send_edit(KIND_BKSP,      '0, '0, '0);
		send_edit(KIND_RD_AT,     13'd2, '0, '0);	// read at end -> none
		send_edit(KIND_RD_AT,     13'd4, '0, '0);	// past end -> range
	endtask

	// Random edits on a short text, with idle and stall bursts switched per block of items.
	task automatic test_random_edits(int count);
		kind_t k;
		pos_t  p;
		logic signed [13:0] d;
		int    r;
		int    span;

		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				src_bursts  = ($urandom_range(0, 3) != 0);
				sink_bursts = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			// keep the text short so gap moves stay cheap; deletes win once it grows
			if (txt_len > 56)
				k = (r < 50) ? KIND_BKSP : (r < 80) ? KIND_FDEL : kind_t'($urandom_range(0, 7));
			else if (r < 35)
				k = KIND_INSERT;
			else
				k = kind_t'($urandom_range(0, 7));
			span = txt_len + 2;
			if ($urandom_range(0, 9) < 7)
				p = pos_t'($urandom_range(0, txt_len + 1));
			else
				p = pos_t'($urandom);
			if ($urandom_range(0, 9) < 7)
				d = 14'($urandom_range(0, 2 * span) - span);
			else
				d = 14'($urandom);
			send_edit(k, p, d, char_t'($urandom));
		end
	endtask

	// Fill to capacity, check the full refusal, then edit at both ends and the middle.
	// No idling here.
	task automatic test_fill_to_capacity();
		src_bursts  = 1'b0;
		sink_bursts = 1'b0;
		send_edit(KIND_SET, pos_t'(txt_len), '0, '0);
		while (txt_len < CAPACITY)
			send_edit(KIND_INSERT, '0, '0, char_t'($urandom));
		send_edit(KIND_INSERT,    '0, '0, 8'h11);	// full at end
		send_edit(KIND_SET,       13'd0, '0, '0);
		send_edit(KIND_INSERT,    '0, '0, 8'h22);	// full at start, gap stays put
		send_edit(KIND_BKSP,      '0, '0, '0);		// start -> none
		send_edit(KIND_RD_BEFORE, '0, '0, '0);
		send_edit(KIND_MOVE,      '0, 14'sd4096, '0);	// jump to the very end
		send_edit(KIND_RD_CUR,    '0, '0, '0);
		send_edit(KIND_RD_AT,     13'd4095, '0, '0);
		send_edit(KIND_RD_AT,     13'd4096, '0, '0);
		send_edit(KIND_RD_AT,     13'd4097, '0, '0);
		send_edit(KIND_MOVE,      '0, -14'sd4096, '0);
		send_edit(KIND_FDEL,      '0, '0, '0);		// whole text crosses the gap
		send_edit(KIND_INSERT,    '0, '0, 8'h33);
		send_edit(KIND_SET,       13'd2048, '0, '0);
		send_edit(KIND_BKSP,      '0, '0, '0);
		send_edit(KIND_INSERT,    '0, '0, 8'h44);
		send_edit(KIND_INSERT,    '0, '0, 8'h55);	// full again
		send_edit(KIND_SET,       13'd4096, '0, '0);
		send_edit(KIND_BKSP,      '0, '0, '0);
		send_edit(KIND_FDEL,      '0, '0, '0);		// end -> none
		send_edit(KIND_RD_AT,     13'd0, '0, '0);
	endtask

	initial begin
		txt_len      = 0;
		txt_cursor   = 0;
		mismatches   = 0;
		edits_sent   = 0;
		results_seen = 0;
		max_len_seen = 0;
		src_bursts   = 1'b1;
		sink_bursts  = 1'b1;
		foreach (status_seen[i])
			status_seen[i] = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random_edits(800);
		test_fill_to_capacity();
		s_axis_tvalid <= 1'b0;

		// drain, then give a stray result time to show up
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d edits, %0d results: ok %0d, none %0d, range %0d, full %0d.",
			edits_sent, results_seen, status_seen[ST_OK], status_seen[ST_NONE],
			status_seen[ST_RANGE], status_seen[ST_FULL]);
		$display("Text reached %0d of %0d bytes; %0d mismatches.",
			max_len_seen, CAPACITY, mismatches);
		if (mismatches == 0)
			$display("gap_buffer_text_editor test passed");
		else
			$display("gap_buffer_text_editor test failed");
		$finish;
	end

	// Watchdog: reports a failure if the run has not finished by the timeout.
	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding.", expected_results.size());
		$display("gap_buffer_text_editor test failed");
		$finish;
	end

endmodule

// File: sim.f
design/gbte_pkg.sv
design/gbte_mem.sv
design/gbte_ctrl.sv
design/gap_buffer_text_editor.sv
design/gbte_checker.sv
bench/tb_top.sv
